// ===== src/matrix_vector_multiply_defines.svh =====
// Assertion macros used by the checker of the matrix-vector block.
// No dependencies; the including file must provide clk and rst in scope.
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Checked on every rising edge outside reset.
`define MVM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MVM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mvm_pkg.sv =====
// Shared types and constants for the matrix-vector multiply block.
// No dependencies; every module of the block but mvm_ram imports this package.
package mvm_pkg;

  localparam int ROWS_W      = 16;
  localparam int COUNT_W     = 9;
  localparam int ACC_W       = 64;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int LEVEL_W     = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [15:0]        row_index;
    logic               last;
    logic               saturated;
  } out_item_t;

  // One matrix element with its vector element, as handed from front to back.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               row_end;
    logic [ROWS_W-1:0]  row_index;
    logic               last;
  } mac_op_t;

endpackage

// ===== src/mvm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mvm_front.sv =====
// Front end: accepts transactions, loads the vector store and tags matrix elements.
// Depends on mvm_pkg and mvm_ram.
module mvm_front #(
  parameter int MAX_COLS   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mvm_pkg::in_item_t              in_data,
  input  logic [mvm_pkg::ROWS_W-1:0]     num_rows,
  input  logic [mvm_pkg::COUNT_W-1:0]    num_cols,
  input  logic [mvm_pkg::LEVEL_W-1:0]    queue_level,
  output logic                           push,
  output mvm_pkg::mac_op_t               push_op
);
  import mvm_pkg::*;

  localparam int IDX_W = $clog2(MAX_COLS);

  logic [COUNT_W-1:0] cols_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic [COUNT_W-1:0] load_count, load_count_next;
  logic [COUNT_W-1:0] column_count, column_count_next;
  logic [ROWS_W-1:0]  row_count, row_count_next;
  logic [COUNT_W-1:0] load_idx, col;
  logic [ROWS_W-1:0]  row;
  logic               row_end, is_last;
  logic               accept, is_matrix;
  logic signed [31:0] x;
  logic [DATA_WIDTH-1:0] rd_data;
  logic               f1_valid;
  mac_op_t            f1_op;

  always_comb begin
    if (num_cols == '0) begin
      cols_eff = COUNT_W'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      cols_eff = COUNT_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols;
    end
    rows_eff = (num_rows == '0) ? ROWS_W'(1) : num_rows;
  end

  assign accept    = in_valid && in_ready;
  assign is_matrix = (in_data.operation == OP_MATRIX);
  assign x         = 32'(signed'(in_data.value[DATA_WIDTH-1:0]));

  // Counters past a shrunken bound act as the last position; a stray load goes to entry 0.
  always_comb begin
    load_idx = (load_count < cols_eff) ? load_count : '0;
    load_count_next = (({1'b0, load_idx} + 1'b1) >= {1'b0, cols_eff}) ? '0 : load_idx + 1'b1;
    col = (column_count < cols_eff) ? column_count : cols_eff - 1'b1;
    row_end = (({1'b0, col} + 1'b1) >= {1'b0, cols_eff});
    column_count_next = row_end ? '0 : col + 1'b1;
    row = (row_count < rows_eff) ? row_count : rows_eff - 1'b1;
    is_last = (({1'b0, row} + 1'b1) >= {1'b0, rows_eff});
    row_count_next = is_last ? '0 : row + 1'b1;
  end

  mvm_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_COLS)
  ) u_vector_store (
    .clk    (clk),
    .wr_en  (accept && !is_matrix),
    .wr_addr(IDX_W'(load_idx)),
    .wr_data(in_data.value[DATA_WIDTH-1:0]),
    .rd_en  (accept && is_matrix),
    .rd_addr(IDX_W'(col)),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      column_count <= '0;
      row_count    <= '0;
      f1_valid     <= 1'b0;
    end else begin
      f1_valid <= accept && is_matrix;
      if (accept) begin
        if (is_matrix) begin
          column_count <= column_count_next;
          if (row_end) begin
            row_count <= row_count_next;
          end
        end else begin
          load_count <= load_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_matrix) begin
      f1_op.a         <= x;
      f1_op.b         <= '0;
      f1_op.row_end   <= row_end;
      f1_op.row_index <= row;
      f1_op.last      <= is_last;
    end
  end

  // The vector element arrives from the store in the cycle after the lookup.
  always_comb begin
    push_op   = f1_op;
    push_op.b = 32'(signed'(rd_data));
  end

  assign push = f1_valid;

  // Room is reserved for the element still waiting on the store read.
  assign in_ready = ((4'(queue_level) + 4'(f1_valid)) < 4'(QUEUE_DEPTH));

endmodule

// ===== src/mvm_queue.sv =====
// Short FIFO of tagged multiply-accumulate operations between front and back.
// Depends on mvm_pkg.
module mvm_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mvm_pkg::mac_op_t            push_op,
  input  logic                        pop,
  output logic                        head_valid,
  output mvm_pkg::mac_op_t            head,
  output logic [mvm_pkg::LEVEL_W-1:0] level
);
  import mvm_pkg::*;

  mac_op_t                store [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LEVEL_W-1:0]     count;
  logic                   do_pop;

  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign level      = count;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + LEVEL_W'(push) - LEVEL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_op;
    end
  end

endmodule

// ===== src/mvm_back.sv =====
// Back end: multiply, saturating accumulate, and row-end rounding into the output register.
// Depends on mvm_pkg.
module mvm_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mvm_pkg::mac_op_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mvm_pkg::out_item_t out_data
);
  import mvm_pkg::*;

  localparam int TOP_LSB = FRAC_BITS + DATA_WIDTH - 1;

  logic signed [DATA_WIDTH-1:0]   op_a, op_b;
  logic signed [2*DATA_WIDTH-1:0] prod;

  logic                    m_valid, m_row_end, m_last;
  logic signed [ACC_W-1:0] m_prod;
  logic [ROWS_W-1:0]       m_row_index;

  logic signed [ACC_W-1:0] acc, sum, acc_sat;
  logic                    ovf, ovf_now;

  logic                    fin_valid, fin_sat, fin_last;
  logic signed [ACC_W-1:0] fin_sum;
  logic [ROWS_W-1:0]       fin_row_index;

  logic out_load, fin_adv, fin_free, m_fire, m_free;
  logic [ACC_W-1-TOP_LSB:0] top_bits;
  logic                     out_sat;
  logic [DATA_WIDTH-1:0]    res_dw;

  assign out_load = !out_valid || out_ready;
  assign fin_adv  = fin_valid && out_load;
  assign fin_free = !fin_valid || fin_adv;
  assign m_fire   = m_valid && (!m_row_end || fin_free);
  assign m_free   = !m_valid || m_fire;
  assign pop      = head_valid && m_free;

  assign op_a = signed'(head.a[DATA_WIDTH-1:0]);
  assign op_b = signed'(head.b[DATA_WIDTH-1:0]);
  assign prod = op_a * op_b;

  // Overflow only when both addends share a sign and the sum does not.
  always_comb begin
    sum     = acc + m_prod;
    ovf_now = (acc[ACC_W-1] == m_prod[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1]);
    if (ovf_now) begin
      acc_sat = acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = sum;
    end
  end

  // Dropping the fraction bits floors the sum; the rest must fit in the data width.
  always_comb begin
    top_bits = fin_sum[ACC_W-1:TOP_LSB];
    out_sat  = !((&top_bits) || !(|top_bits));
    if (out_sat) begin
      res_dw = fin_sum[ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      res_dw = fin_sum[TOP_LSB:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      ovf       <= 1'b0;
    end else begin
      if (m_free) begin
        m_valid <= head_valid;
      end
      if (m_fire) begin
        if (m_row_end) begin
          acc <= '0;
          ovf <= 1'b0;
        end else begin
          acc <= acc_sat;
          ovf <= ovf || ovf_now;
        end
      end
      if (m_fire && m_row_end) begin
        fin_valid <= 1'b1;
      end else if (fin_adv) begin
        fin_valid <= 1'b0;
      end
      if (fin_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod      <= ACC_W'(prod);
      m_row_end   <= head.row_end;
      m_row_index <= head.row_index;
      m_last      <= head.last;
    end
    if (m_fire && m_row_end) begin
      fin_sum       <= acc_sat;
      fin_sat       <= ovf || ovf_now;
      fin_row_index <= m_row_index;
      fin_last      <= m_last;
    end
    if (fin_adv) begin
      out_data.result    <= 32'(signed'(res_dw));
      out_data.row_index <= fin_row_index;
      out_data.last      <= fin_last;
      out_data.saturated <= fin_sat || out_sat;
    end
  end

endmodule

// ===== src/matrix_vector_multiply.sv =====
// Matrix-vector multiply in signed Q16.16 with a saturating 64-bit accumulator.
// Throughput: one transaction per cycle while the queue has room, set by the single
// multiply-accumulate in the back end. After its last matrix element is accepted, a row
// result passes the store-read, queue, product, row-sum and output stages and output stalls.
// Reset clears all counters, the accumulator and the pipeline; both registers return to 1.
// The vector store is not cleared and needs no clearing pass.
module matrix_vector_multiply #(
  parameter int MAX_COLS   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mvm_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mvm_pkg::out_item_t                 out_data,
  input  logic                               cfg_write,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mvm_pkg::*;

  logic [ROWS_W-1:0]  num_rows;
  logic [COUNT_W-1:0] num_cols;
  logic               push, pop, head_valid;
  mac_op_t            push_op, head;
  logic [LEVEL_W-1:0] queue_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= ROWS_W'(1);
      num_cols <= COUNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  mvm_front #(
    .MAX_COLS  (MAX_COLS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .num_rows   (num_rows),
    .num_cols   (num_cols),
    .queue_level(queue_level),
    .push       (push),
    .push_op    (push_op)
  );

  mvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .level     (queue_level)
  );

  mvm_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/mvm_checker.sv =====
// Port-level checker for the matrix-vector multiply block, bound to the top level.
// Depends on mvm_pkg and matrix_vector_multiply_defines.svh.
`include "matrix_vector_multiply_defines.svh"

module mvm_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input mvm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mvm_pkg::out_item_t out_data
);
  import mvm_pkg::*;

  logic [32-DATA_WIDTH:0] res_top;
  logic                   in_seen;

  assign res_top = out_data.result[31:DATA_WIDTH-1];
  assign in_seen = in_valid && in_data.operation;

  // A pending result transaction must stay put until it is taken.
  `MVM_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `MVM_ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")

  // Out of reset the block is empty and ready for a transaction.
  `MVM_ASSERT_ALWAYS(a_reset_idle, rst |=> in_ready && !out_valid, "not idle after reset")

  // Every result is a sign-extended value of the data width, saturated or not.
  `MVM_ASSERT_CLK(a_result_range, out_valid |-> (&res_top) || !(|res_top) || in_seen && 1'b0, "result outside data width")

endmodule

bind matrix_vector_multiply mvm_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);
